@@ hdl/dstwr_pkg.sv @@
package dstwr_pkg;

  localparam int STAMP_BITS = 40;
  localparam int DELAY_BITS = 16;
  localparam int UUS_SHIFT  = 16;
  localparam int TIME_LSB   = 8;
  localparam int DIV_BITS   = 64;
  localparam int DEN_BITS   = 34;

  localparam logic [DELAY_BITS-1:0] DELAY_RESET = 16'd6000;

  localparam logic [1:0] OP_POLL  = 2'd0;
  localparam logic [1:0] OP_FINAL = 2'd1;
  localparam logic [1:0] OP_ERROR = 2'd2;
  localparam logic [1:0] OP_LATE  = 2'd3;

  localparam logic [1:0] KIND_NONE     = 2'd0;
  localparam logic [1:0] KIND_RESPONSE = 2'd1;
  localparam logic [1:0] KIND_RANGE    = 2'd2;
  localparam logic [1:0] KIND_ABANDON  = 2'd3;

  typedef struct packed {
    logic [1:0]            op;
    logic                  header_ok;
    logic [7:0]            frame_seq;
    logic [STAMP_BITS-1:0] local_rx_time;
    logic [STAMP_BITS-1:0] local_tx_time;
    logic [31:0]           remote_poll_tx;
    logic [31:0]           remote_resp_rx;
    logic [31:0]           remote_final_tx;
  } in_item_t;

  typedef struct packed {
    logic [1:0]         kind;
    logic [31:0]        response_time;
    logic [7:0]         response_seq;
    logic signed [31:0] flight_ticks;
    logic [7:0]         poll_seq;
  } out_item_t;

endpackage

@@ hdl/ds_twr_responder_tof_core.sv @@
// Responder side of double-sided two-way ranging.
// Input channel in_valid/in_stall/in_item carries one radio event per transfer
// (poll, final, receive error or timeout, late transmit start). Output channel
// out_valid/out_stall/out_item returns exactly one result per event.
// cfg_we/cfg_data write the reply delay in UWB microseconds at any idle time.
// Path: an event that needs no range computation goes from S_IDLE to S_WRITE and
// is then loaded into the output register. A valid final awaited after a poll
// goes through two multiplies on one shared 32x32 multiplier, a magnitude
// subtract, a radix-2 restoring divide of 64 steps (skipped, with a zero result,
// when the denominator is zero), saturation and output. in_stall stays high until
// the result of the current event has been loaded into the output register, so
// one event is in work at a time and the core takes no new event before the
// result of the last one is loaded.
// A full output register stalled by the receiver holds its item and holds off
// the next result.
// Reset clears the exchange state, the sequence counter, the output valid and
// loads the reply delay with 6000.
module ds_twr_responder_tof_core (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  dstwr_pkg::in_item_t              in_item,
  output logic                             out_valid,
  input  logic                             out_stall,
  output dstwr_pkg::out_item_t             out_item,
  input  logic                             cfg_we,
  input  logic [dstwr_pkg::DELAY_BITS-1:0] cfg_data
);
  import dstwr_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_MUL_A = 3'd1;
  localparam logic [2:0] S_MUL_B = 3'd2;
  localparam logic [2:0] S_PREP  = 3'd3;
  localparam logic [2:0] S_DIV   = 3'd4;
  localparam logic [2:0] S_SAT   = 3'd5;
  localparam logic [2:0] S_WRITE = 3'd6;

  localparam logic [31:0] TICKS_MAX = 32'h7FFF_FFFF;
  localparam logic [31:0] TICKS_MIN = 32'h8000_0000;

  logic [2:0]            state;
  logic [DELAY_BITS-1:0] reply_delay;
  logic                  awaiting;
  logic [STAMP_BITS-1:0] poll_rx_stamp;
  logic [7:0]            tx_seq_counter;
  logic [7:0]            stored_poll_seq;
  logic [31:0]           ra;
  logic [31:0]           rb;
  logic [31:0]           da;
  logic [31:0]           db;
  logic [DEN_BITS-1:0]   den;
  logic [DIV_BITS-1:0]   prod_p;
  logic [DIV_BITS-1:0]   prod_q;
  logic                  neg;
  out_item_t             res;

  logic                  in_acc;
  logic                  out_free;
  logic                  load_out;
  logic [63:0]           t_sum;
  logic [31:0]           mul_x;
  logic [31:0]           mul_y;
  logic [DIV_BITS-1:0]   product;
  logic [DIV_BITS-1:0]   mag;
  logic                  div_start;
  logic                  div_done;
  logic [DIV_BITS-1:0]   quo;
  logic [31:0]           sat_ticks;

  assign in_stall = (state != S_IDLE);
  assign in_acc   = in_valid & ~in_stall;
  assign out_free = ~out_valid | ~out_stall;
  assign load_out = (state == S_WRITE) && out_free;

  assign t_sum   = 64'(in_item.local_rx_time) + 64'({reply_delay, {UUS_SHIFT{1'b0}}});
  assign mul_x   = (state == S_MUL_A) ? ra : da;
  assign mul_y   = (state == S_MUL_A) ? rb : db;
  assign product = DIV_BITS'(mul_x) * DIV_BITS'(mul_y);
  assign mag     = (prod_p >= prod_q) ? (prod_p - prod_q) : (prod_q - prod_p);

  assign div_start = (state == S_PREP) && (den != '0);

  dstwr_divider u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (mag),
    .divisor  (den),
    .done     (div_done),
    .quotient (quo)
  );

  always_comb begin
    if (!neg) begin
      sat_ticks = (|quo[DIV_BITS-1:31]) ? TICKS_MAX : quo[31:0];
    end else if ((|quo[DIV_BITS-1:32]) || (quo[31] && (|quo[30:0]))) begin
      sat_ticks = TICKS_MIN;
    end else begin
      sat_ticks = 32'd0 - quo[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_IDLE;
      out_valid       <= 1'b0;
      awaiting        <= 1'b0;
      poll_rx_stamp   <= '0;
      tx_seq_counter  <= '0;
      stored_poll_seq <= '0;
      reply_delay     <= DELAY_RESET;
    end else begin
      if (cfg_we) begin
        reply_delay <= cfg_data;
      end
      if (load_out) begin
        out_item  <= res;
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_acc) begin
            state <= (awaiting && in_item.op == OP_FINAL && in_item.header_ok) ?
                     S_MUL_A : S_WRITE;
            if (!awaiting) begin
              if (in_item.op == OP_POLL && in_item.header_ok) begin
                poll_rx_stamp   <= in_item.local_rx_time;
                stored_poll_seq <= in_item.frame_seq;
                awaiting        <= 1'b1;
                res <= {KIND_RESPONSE, t_sum[TIME_LSB +: 32], tx_seq_counter,
                        32'd0, in_item.frame_seq};
              end else begin
                res <= '0;
              end
            end else begin
              awaiting <= 1'b0;
              if (in_item.op == OP_LATE) begin
                res <= {KIND_ABANDON, 32'd0, 8'd0, 32'd0, stored_poll_seq};
              end else begin
                tx_seq_counter <= tx_seq_counter + 8'd1;
                if (in_item.op == OP_FINAL && in_item.header_ok) begin
                  res <= {KIND_RANGE, 32'd0, 8'd0, 32'd0, stored_poll_seq};
                  ra  <= in_item.remote_resp_rx - in_item.remote_poll_tx;
                  rb  <= in_item.local_rx_time[31:0] - in_item.local_tx_time[31:0];
                  da  <= in_item.remote_final_tx - in_item.remote_resp_rx;
                  db  <= in_item.local_tx_time[31:0] - poll_rx_stamp[31:0];
                end else begin
                  res <= {KIND_ABANDON, 32'd0, 8'd0, 32'd0, stored_poll_seq};
                end
              end
            end
          end
        end
        S_MUL_A: begin
          prod_p <= product;
          den    <= DEN_BITS'(ra) + DEN_BITS'(rb) + DEN_BITS'(da) + DEN_BITS'(db);
          state  <= S_MUL_B;
        end
        S_MUL_B: begin
          prod_q <= product;
          state  <= S_PREP;
        end
        S_PREP: begin
          neg   <= (prod_p < prod_q);
          state <= (den == '0) ? S_WRITE : S_DIV;
        end
        S_DIV: begin
          if (div_done) begin
            state <= S_SAT;
          end
        end
        S_SAT: begin
          res.flight_ticks <= sat_ticks;
          state            <= S_WRITE;
        end
        S_WRITE: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_done_in_div: assert property (@(posedge clk) disable iff (rst)
    div_done |-> state == S_DIV)
    else $error("divide finished outside the divide state");
  a_exchange_closes: assert property (@(posedge clk) disable iff (rst)
    in_acc && awaiting |=> !awaiting)
    else $error("exchange left open after an event");
  a_ticks_only_range: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_item.kind != KIND_RANGE |-> out_item.flight_ticks == 0)
    else $error("flight ticks set on a result that is not a range");

endmodule

@@ hdl/dstwr_divider.sv @@
module dstwr_divider (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [dstwr_pkg::DIV_BITS-1:0] dividend,
  input  logic [dstwr_pkg::DEN_BITS-1:0] divisor,
  output logic                          done,
  output logic [dstwr_pkg::DIV_BITS-1:0] quotient
);
  import dstwr_pkg::*;

  localparam int CNT_BITS = $clog2(DIV_BITS + 1);
  localparam logic [CNT_BITS-1:0] LAST_STEP = CNT_BITS'(DIV_BITS - 1);

  logic                busy;
  logic [CNT_BITS-1:0] count;
  logic [DEN_BITS-1:0] den;
  logic [DEN_BITS-1:0] rem;
  logic [DEN_BITS:0]   shifted;
  logic [DEN_BITS+1:0] diff;

  assign shifted = {rem, quotient[DIV_BITS-1]};
  assign diff    = {1'b0, shifted} - {2'b00, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy     <= 1'b1;
        count    <= '0;
        den      <= divisor;
        rem      <= '0;
        quotient <= dividend;
      end else if (busy) begin
        if (diff[DEN_BITS+1]) begin
          rem <= shifted[DEN_BITS-1:0];
        end else begin
          rem <= diff[DEN_BITS-1:0];
        end
        quotient <= {quotient[DIV_BITS-2:0], ~diff[DEN_BITS+1]};
        count    <= count + 1'b1;
        if (count == LAST_STEP) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  a_start_idle: assert property (@(posedge clk) disable iff (rst) start |-> !busy)
    else $error("divider started while busy");
  a_done_pulse: assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("divider done held longer than one cycle");
  a_done_after_busy: assert property (@(posedge clk) disable iff (rst) done |-> $past(busy))
    else $error("divider done without a running division");

endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;
  import dstwr_pkg::*;

  localparam int LIMIT        = 500000;
  localparam int RANDOM_ITEMS = 750;
  localparam int PHASES       = 6;
  localparam int MAX_SHOWN    = 10;
  localparam logic [STAMP_BITS-1:0] STAMP_MAX = {STAMP_BITS{1'b1}};

  typedef struct {
    in_item_t  ev;
    bit        fixed;
    out_item_t want;
  } dir_row_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  in_item_t              in_item = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  out_item_t             out_item;
  logic                  cfg_we = 1'b0;
  logic [DELAY_BITS-1:0] cfg_data = '0;

  logic      row_fixed = 1'b0;
  out_item_t row_want = '0;

  logic [DELAY_BITS-1:0] delay_uus = DELAY_RESET;
  bit                    await_final = 1'b0;
  logic [STAMP_BITS-1:0] poll_stamp = '0;
  logic [7:0]            seq_ctr = '0;
  logic [7:0]            poll_seq_held = '0;

  out_item_t pending_results[$];
  int        fails = 0;
  int        accepted = 0;
  int        active_events = 0;
  int        kind_count[4] = '{0, 0, 0, 0};
  int        cycles = 0;
  int        stall_mode = 0;
  logic [5:0] stall_tick = '0;
  int        burst_left = 0;
  bit        gaps_on = 1'b0;
  dir_row_t  rows[$];

  always #1 clk = ~clk;

  ds_twr_responder_tof_core i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data)
  );

  function automatic logic [31:0] flight_of(in_item_t ev);
    logic [31:0] ra, rb, da, db;
    logic [63:0] p, q, den, quo;
    ra = ev.remote_resp_rx - ev.remote_poll_tx;
    rb = ev.local_rx_time[31:0] - ev.local_tx_time[31:0];
    da = ev.remote_final_tx - ev.remote_resp_rx;
    db = ev.local_tx_time[31:0] - poll_stamp[31:0];
    p = 64'(ra) * 64'(rb);
    q = 64'(da) * 64'(db);
    den = 64'(ra) + 64'(rb) + 64'(da) + 64'(db);
    if (den == 64'd0) return 32'd0;
    if (p >= q) begin
      quo = (p - q) / den;
      return (quo > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : quo[31:0];
    end
    quo = (q - p) / den;
    if (quo > 64'h8000_0000) quo = 64'h8000_0000;
    return 32'd0 - quo[31:0];
  endfunction

  function automatic out_item_t predict_event(in_item_t ev);
    out_item_t r;
    logic [63:0] t;
    r = '0;
    if (!await_final) begin
      if (ev.op == OP_POLL && ev.header_ok) begin
        t = 64'(ev.local_rx_time) + (64'(delay_uus) << UUS_SHIFT);
        poll_stamp = ev.local_rx_time;
        poll_seq_held = ev.frame_seq;
        await_final = 1'b1;
        r.kind = KIND_RESPONSE;
        r.response_time = t[TIME_LSB +: 32];
        r.response_seq = seq_ctr;
        r.poll_seq = poll_seq_held;
      end
    end else begin
      await_final = 1'b0;
      r.poll_seq = poll_seq_held;
      r.kind = KIND_ABANDON;
      if (ev.op != OP_LATE) begin
        seq_ctr = seq_ctr + 8'd1;
        if (ev.op == OP_FINAL && ev.header_ok) begin
          r.kind = KIND_RANGE;
          r.flight_ticks = flight_of(ev);
        end
      end
    end
    return r;
  endfunction

  always @(posedge clk) begin
    out_item_t want, got;
    if (!rst) begin
      if (out_valid && !out_stall) begin
        got = out_item;
        if (pending_results.size() == 0) begin
          fails++;
          if (fails <= MAX_SHOWN)
            $display("unexpected result: kind %0d time %h rseq %h tof %0d pseq %h",
                     got.kind, got.response_time, got.response_seq, got.flight_ticks,
                     got.poll_seq);
        end else begin
          want = pending_results.pop_front();
          kind_count[want.kind]++;
          if (got.kind !== want.kind || got.response_time !== want.response_time ||
              got.response_seq !== want.response_seq ||
              got.flight_ticks !== want.flight_ticks || got.poll_seq !== want.poll_seq) begin
            fails++;
            if (fails <= MAX_SHOWN)
              $display({"mismatch (exp/got): kind %0d/%0d time %h/%h rseq %h/%h ",
                        "tof %0d/%0d pseq %h/%h"},
                       want.kind, got.kind, want.response_time, got.response_time,
                       want.response_seq, got.response_seq, want.flight_ticks,
                       got.flight_ticks, want.poll_seq, got.poll_seq);
          end
        end
      end
      if (in_valid && !in_stall) begin
        got = predict_event(in_item);
        accepted++;
        if (got.kind != KIND_NONE) active_events++;
        pending_results.push_back(row_fixed ? row_want : got);
      end
    end
  end

  always @(posedge clk) begin
    stall_tick <= stall_tick + 6'd1;
    case (stall_mode)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 2) == 0);
      default: out_stall <= (stall_tick[5:4] == 2'b11);
    endcase
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles,
               pending_results.size());
      $display("status: fail");
      $finish;
    end
  end

  function automatic in_item_t rand_event();
    in_item_t ev;
    ev.op = 2'($urandom_range(0, 3));
    ev.header_ok = 1'($urandom_range(0, 1));
    ev.frame_seq = 8'($urandom());
    ev.local_rx_time = STAMP_BITS'({$urandom(), $urandom()});
    ev.local_tx_time = STAMP_BITS'({$urandom(), $urandom()});
    ev.remote_poll_tx = $urandom();
    ev.remote_resp_rx = $urandom();
    ev.remote_final_tx = $urandom();
    return ev;
  endfunction

  function automatic in_item_t mk_ev(logic [1:0] op, logic hdr, logic [7:0] seq,
                                     logic [STAMP_BITS-1:0] rx, logic [STAMP_BITS-1:0] tx,
                                     logic [31:0] rp, logic [31:0] rr, logic [31:0] rf);
    in_item_t ev;
    ev.op = op;
    ev.header_ok = hdr;
    ev.frame_seq = seq;
    ev.local_rx_time = rx;
    ev.local_tx_time = tx;
    ev.remote_poll_tx = rp;
    ev.remote_resp_rx = rr;
    ev.remote_final_tx = rf;
    return ev;
  endfunction

  function automatic out_item_t mk_out(logic [1:0] kind, logic [31:0] rtime,
                                       logic [7:0] rseq, logic [31:0] tof, logic [7:0] pseq);
    out_item_t r;
    r.kind = kind;
    r.response_time = rtime;
    r.response_seq = rseq;
    r.flight_ticks = tof;
    r.poll_seq = pseq;
    return r;
  endfunction

  function automatic void add_row(in_item_t ev, bit fixed, out_item_t want);
    dir_row_t row;
    row.ev = ev;
    row.fixed = fixed;
    row.want = want;
    rows.push_back(row);
  endfunction

  task automatic send(in_item_t ev, bit fixed, out_item_t want);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      if (gaps_on) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    in_item <= ev;
    row_fixed <= fixed;
    row_want <= want;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_delay(logic [DELAY_BITS-1:0] value);
    drain();
    cfg_we <= 1'b1;
    cfg_data <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    delay_uus = value;
  endtask

  // build a poll/final pair, mostly with consistent intervals around a small flight time
  task automatic run_exchange();
    in_item_t poll_ev, fin_ev;
    logic [31:0] tof2, ra, rb, da, db;
    poll_ev = rand_event();
    poll_ev.op = OP_POLL;
    poll_ev.header_ok = 1'b1;
    fin_ev = rand_event();
    fin_ev.op = OP_FINAL;
    fin_ev.header_ok = 1'b1;
    if ($urandom_range(0, 3) != 0) begin
      tof2 = $urandom_range(0, 4000);
      da = $urandom() >> $urandom_range(1, 31);
      db = $urandom() >> $urandom_range(1, 31);
      ra = db + tof2 + $urandom_range(0, 16);
      rb = da + tof2 + $urandom_range(0, 16);
      fin_ev.remote_resp_rx = fin_ev.remote_poll_tx + ra;
      fin_ev.remote_final_tx = fin_ev.remote_resp_rx + da;
      fin_ev.local_tx_time = poll_ev.local_rx_time + STAMP_BITS'(db);
      fin_ev.local_rx_time = fin_ev.local_tx_time + STAMP_BITS'(rb);
    end
    send(poll_ev, 1'b0, '0);
    send(fin_ev, 1'b0, '0);
  endtask

  logic [DELAY_BITS-1:0] delay_plan[PHASES];

  initial begin
    in_item_t ev;
    int goal;
    int pick;
    out_item_t none;
    none = mk_out(KIND_NONE, 32'd0, 8'd0, 32'd0, 8'd0);

    add_row(mk_ev(OP_FINAL, 1'b1, 8'h00, '0, '0, '0, '0, '0), 1'b1, none);
    add_row(mk_ev(OP_ERROR, 1'b1, 8'hFF, STAMP_MAX, STAMP_MAX, '1, '1, '1), 1'b1, none);
    add_row(mk_ev(OP_LATE, 1'b0, 8'h55, '0, STAMP_MAX, '0, '1, '0), 1'b1, none);
    add_row(mk_ev(OP_POLL, 1'b0, 8'h33, STAMP_MAX, '0, '1, '0, '1), 1'b1, none);
    add_row(mk_ev(OP_POLL, 1'b1, 8'hFF, '0, '0, '0, '0, '0), 1'b1,
            mk_out(KIND_RESPONSE, 32'd1536000, 8'd0, 32'd0, 8'hFF));
    add_row(mk_ev(OP_LATE, 1'b1, 8'h01, '0, '0, '0, '0, '0), 1'b1,
            mk_out(KIND_ABANDON, 32'd0, 8'd0, 32'd0, 8'hFF));
    add_row(mk_ev(OP_POLL, 1'b1, 8'h00, STAMP_MAX, '0, '0, '0, '0), 1'b1,
            mk_out(KIND_RESPONSE, 32'd1535999, 8'd0, 32'd0, 8'h00));
    add_row(mk_ev(OP_ERROR, 1'b0, 8'h02, '0, '0, '0, '0, '0), 1'b1,
            mk_out(KIND_ABANDON, 32'd0, 8'd0, 32'd0, 8'h00));
    add_row(mk_ev(OP_POLL, 1'b1, 8'h5A, 40'h00_8000_0000, '0, '0, '0, '0), 1'b0, none);
    add_row(mk_ev(OP_POLL, 1'b1, 8'hA5, '0, '0, '0, '0, '0), 1'b1,
            mk_out(KIND_ABANDON, 32'd0, 8'd0, 32'd0, 8'h5A));
    add_row(mk_ev(OP_POLL, 1'b1, 8'h11, 40'h80_0000_0000, '0, '0, '0, '0), 1'b0, none);
    add_row(mk_ev(OP_FINAL, 1'b0, 8'h11, '0, '0, '0, '0, '0), 1'b1,
            mk_out(KIND_ABANDON, 32'd0, 8'd0, 32'd0, 8'h11));
    add_row(mk_ev(OP_POLL, 1'b1, 8'h3C, 40'h12_3456_789A, '0, '0, '0, '0), 1'b0, none);
    add_row(mk_ev(OP_FINAL, 1'b1, 8'h3D, 40'h12_3456_789A, 40'h12_3456_789A,
                  '1, '1, '1), 1'b1, mk_out(KIND_RANGE, 32'd0, 8'd0, 32'd0, 8'h3C));
    add_row(mk_ev(OP_POLL, 1'b1, 8'h80, '0, '0, '0, '0, '0), 1'b0, none);
    add_row(mk_ev(OP_FINAL, 1'b1, 8'h81, 40'h00_FFFF_FFFF, '0, '0, '1, '1), 1'b0, none);
    add_row(mk_ev(OP_POLL, 1'b1, 8'h7F, '0, '0, '0, '0, '0), 1'b0, none);
    add_row(mk_ev(OP_FINAL, 1'b1, 8'h80, STAMP_MAX, 40'h00_FFFF_FFFF, '0, '0, '1), 1'b0, none);
    ev = rand_event();
    ev.op = OP_POLL;
    ev.header_ok = 1'b1;
    add_row(ev, 1'b0, none);
    ev = rand_event();
    ev.op = OP_FINAL;
    ev.header_ok = 1'b1;
    add_row(ev, 1'b0, none);
    add_row(mk_ev(OP_POLL, 1'b1, 8'hC3, 40'h55_AAAA_5555, '0, '0, '0, '0), 1'b0, none);
    add_row(mk_ev(OP_LATE, 1'b0, 8'h3C, 40'hAA_5555_AAAA, '1, '1, '0, '1), 1'b0, none);

    delay_plan[0] = 16'd0;
    delay_plan[1] = 16'hFFFF;
    delay_plan[2] = 16'($urandom());
    delay_plan[3] = 16'd1;
    delay_plan[4] = 16'($urandom());
    delay_plan[5] = DELAY_RESET;

    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (rows[i]) send(rows[i].ev, rows[i].fixed, rows[i].want);

    goal = accepted;
    for (int ph = 0; ph < PHASES; ph++) begin
      write_delay(delay_plan[ph]);
      stall_mode = ph % 3;
      gaps_on = (ph != 0);
      goal += RANDOM_ITEMS / PHASES;
      while (accepted < goal) begin
        pick = $urandom_range(0, 99);
        if (pick < 65) begin
          run_exchange();
        end else if (pick < 85) begin
          ev = rand_event();
          ev.op = OP_POLL;
          ev.header_ok = 1'b1;
          send(ev, 1'b0, '0);
          send(rand_event(), 1'b0, '0);
        end else begin
          send(rand_event(), 1'b0, '0);
        end
      end
    end

    drain();
    repeat (80) @(posedge clk);
    $display("covered %0d events (%0d acted on) over %0d reply delays from 0 to 65535",
             accepted, active_events, PHASES + 1);
    $display("results: %0d none, %0d response, %0d range, %0d abandoned; %0d mismatches",
             kind_count[KIND_NONE], kind_count[KIND_RESPONSE], kind_count[KIND_RANGE],
             kind_count[KIND_ABANDON], fails);
    if (fails == 0 && pending_results.size() == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule

@@ sim.f @@
hdl/dstwr_pkg.sv
hdl/dstwr_divider.sv
hdl/ds_twr_responder_tof_core.sv
tb/tb_top.sv
